[design/gdhf_pkg.sv]
package gdhf_pkg;

   localparam int DEPTH_W   = 16;
   localparam int GRAY_W    = 8;
   localparam int PIX_W     = DEPTH_W + GRAY_W;
   localparam int ROW_W     = 12;
   localparam int COL_OUT_W = 11;
   localparam int SIZE_W    = 12;
   localparam int SUM_W     = 26;
   localparam int WSUM_W    = 10;
   localparam int QUO_W     = 16;
   localparam int NB_COUNT  = 4;

   localparam int FIFO_DEPTH = 32;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [SIZE_W-1:0]  WIDTH_RESET  = 12'd1024;
   localparam logic [SIZE_W-1:0]  HEIGHT_RESET = 12'd512;
   localparam logic [DEPTH_W-1:0] HOLE_RESET   = 16'd51200;
   localparam logic [GRAY_W-1:0]  THR_RESET    = 8'd10;
   localparam logic [SIZE_W-1:0]  SIZE_MIN     = 12'd3;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT,
      REG_HOLE_VALUE,
      REG_GRAY_THRESHOLD
   } csr_index_type;

   // weight of one neighbor, zero when its depth is at or above the hole value or it is too far off in gray
   function automatic logic [GRAY_W-1:0] nb_weight(input logic [PIX_W-1:0] nb,
                                                   input logic [GRAY_W-1:0] cg,
                                                   input logic [DEPTH_W-1:0] hole,
                                                   input logic [GRAY_W-1:0] thr);
      logic [DEPTH_W-1:0] nd;
      logic [GRAY_W-1:0]  ng;
      logic [GRAY_W-1:0]  diff;
      logic [GRAY_W-1:0]  wt;
      nd   = nb[PIX_W-1:GRAY_W];
      ng   = nb[GRAY_W-1:0];
      diff = (ng > cg) ? (ng - cg) : (cg - ng);
      wt   = '0;
      if ((nd < hole) && (diff < thr)) begin
         wt = thr - diff;
      end
      return wt;
   endfunction

endpackage

[design/guided_depth_hole_fill_pass.sv]
// throughput: one pixel word per cycle while req_ready is high; a last-row pixel yields two
// result words, so the output side then runs at one result word per cycle while rsp_ready is high
// the line store is read once per pixel on two ports and written back in the following cycle
// reset is synchronous and clears control state, configuration and pipeline registers; the line
// store, its read registers and the queue storage are not cleared, and rows are valid once written
module guided_depth_hole_fill_pass import gdhf_pkg::*; #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [DEPTH_W-1:0]   req_depth_in,
   input  logic [GRAY_W-1:0]    req_gray_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DEPTH_W-1:0]   rsp_depth_out,
   output logic [ROW_W-1:0]     rsp_out_row,
   output logic [COL_OUT_W-1:0] rsp_out_col,
   output logic                 rsp_run_last,
   output logic                 rsp_frame_end,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CSR_AW-1:0]    paddr,
   input  logic [CSR_DW-1:0]    pwdata,
   output logic [CSR_DW-1:0]    prdata,
   output logic                 pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);

   typedef struct packed {
      logic               v;
      logic [ROW_W-1:0]   row;
      logic [CW-1:0]      col;
      logic [DEPTH_W-1:0] cd;
      logic [DEPTH_W-1:0] d;
      logic               fill;
      logic               out1;
      logic               out2;
      logic               fe;
   } meta_type;

   typedef struct packed {
      logic               v;
      logic [ROW_W-1:0]   row;
      logic [CW-1:0]      col;
      logic [PIX_W-1:0]   pix;
      logic               inner;
      logic               out1;
      logic               out2;
      logic               fe;
   } s1_type;

   typedef struct packed {
      meta_type                          m;
      logic [NB_COUNT-1:0][DEPTH_W-1:0]  nd;
      logic [NB_COUNT-1:0][GRAY_W-1:0]   wt;
   } s2_type;

   typedef struct packed {
      meta_type                                  m;
      logic [NB_COUNT-1:0][DEPTH_W+GRAY_W-1:0]   prod;
      logic [WSUM_W-1:0]                         wsum;
   } s3_type;

   typedef struct packed {
      meta_type          m;
      logic [SUM_W-1:0]  rem;
      logic [QUO_W-1:0]  q;
      logic [WSUM_W-1:0] wsum;
   } dv_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] d1;
      logic [DEPTH_W-1:0] d2;
      logic [ROW_W-1:0]   row;
      logic [CW-1:0]      col;
      logic               out1;
      logic               out2;
      logic               fe;
   } fifo_type;

   // configuration
   logic [SIZE_W-1:0]  width_ff, height_ff;
   logic [DEPTH_W-1:0] hole_ff;
   logic [GRAY_W-1:0]  thr_ff;
   logic               csr_wr;
   csr_index_type      csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         hole_ff   <= HOLE_RESET;
         thr_ff    <= THR_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_FRAME_WIDTH:    width_ff  <= pwdata[SIZE_W-1:0];
            REG_FRAME_HEIGHT:   height_ff <= pwdata[SIZE_W-1:0];
            REG_HOLE_VALUE:     hole_ff   <= pwdata[DEPTH_W-1:0];
            REG_GRAY_THRESHOLD: thr_ff    <= pwdata[GRAY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_FRAME_WIDTH:    prdata = CSR_DW'(width_ff);
         REG_FRAME_HEIGHT:   prdata = CSR_DW'(height_ff);
         REG_HOLE_VALUE:     prdata = CSR_DW'(hole_ff);
         REG_GRAY_THRESHOLD: prdata = CSR_DW'(thr_ff);
         default:            prdata = '0;
      endcase
   end

   // clamped frame size
   logic [15:0]       fw_ext;
   logic [WW-1:0]     w_cur;
   logic [ROW_W-1:0]  h_cur;

   always_comb begin
      fw_ext = 16'(width_ff);
      if (width_ff < SIZE_MIN) begin
         w_cur = WW'(SIZE_MIN);
      end else if (fw_ext > 16'(MAX_WIDTH)) begin
         w_cur = WW'(MAX_WIDTH);
      end else begin
         w_cur = WW'(width_ff);
      end
      h_cur = (height_ff < SIZE_MIN) ? SIZE_MIN : height_ff;
   end

   // position of the incoming word
   logic [ROW_W-1:0] row_pos_ff, row_pos_in;
   logic [CW-1:0]    col_pos_ff, col_pos_in;
   logic [ROW_W-1:0] ra, rn;
   logic [CW-1:0]    ca;
   logic [WW-1:0]    c_inc;
   logic             acc;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (cnt_ff < CNT_W'(FIFO_DEPTH));
   assign acc       = req_valid && req_ready;

   always_comb begin
      ra = row_pos_ff;
      ca = col_pos_ff;
      if (WW'(col_pos_ff) >= w_cur) begin
         ca = '0;
         ra = row_pos_ff + 1'b1;
      end
      if (ra >= h_cur) begin
         ra = '0;
      end
      c_inc      = WW'(ca) + 1'b1;
      col_pos_in = CW'(c_inc);
      rn         = ra;
      if (c_inc >= w_cur) begin
         col_pos_in = '0;
         rn         = ra + 1'b1;
         if (rn >= h_cur) begin
            rn = '0;
         end
      end
      row_pos_in = rn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         col_pos_ff <= '0;
      end else if (acc) begin
         row_pos_ff <= row_pos_in;
         col_pos_ff <= col_pos_in;
      end
   end

   // line store: {older row, previous row} per column
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd1_ff, rd2_ff;
   s1_type             s1_ff, s1_in;
   logic [PIX_W-1:0]   prev_c, older_c, right_c;

   assign prev_c  = rd1_ff[PIX_W-1:0];
   assign older_c = rd1_ff[2*PIX_W-1:PIX_W];
   assign right_c = rd2_ff[PIX_W-1:0];

   always_ff @(posedge clock) begin
      if (s1_ff.v) begin
         line_mem[s1_ff.col] <= {prev_c, s1_ff.pix};
      end
      rd1_ff <= line_mem[ca];
      rd2_ff <= line_mem[CW'(c_inc)];
   end

   always_comb begin
      s1_in.v     = acc;
      s1_in.row   = ra;
      s1_in.col   = ca;
      s1_in.pix   = {req_depth_in, req_gray_in};
      s1_in.inner = (ra >= ROW_W'(2)) && (ca != '0) && (c_inc < w_cur);
      s1_in.out1  = (ra != '0);
      s1_in.out2  = (ra == h_cur - 1'b1);
      s1_in.fe    = (c_inc == w_cur);
   end

   // stage 1: neighbor weights
   logic [PIX_W-1:0]  win0_ff;
   logic [GRAY_W-1:0] cg;
   s2_type            s2_ff, s2_in;

   assign cg = prev_c[GRAY_W-1:0];

   always_comb begin
      s2_in.m.v    = s1_ff.v;
      s2_in.m.row  = s1_ff.row;
      s2_in.m.col  = s1_ff.col;
      s2_in.m.cd   = prev_c[PIX_W-1:GRAY_W];
      s2_in.m.d    = s1_ff.pix[PIX_W-1:GRAY_W];
      s2_in.m.fill = s1_ff.inner && (prev_c[PIX_W-1:GRAY_W] == hole_ff);
      s2_in.m.out1 = s1_ff.out1;
      s2_in.m.out2 = s1_ff.out2;
      s2_in.m.fe   = s1_ff.fe;
      s2_in.nd[0]  = older_c[PIX_W-1:GRAY_W];
      s2_in.nd[1]  = s1_ff.pix[PIX_W-1:GRAY_W];
      s2_in.nd[2]  = win0_ff[PIX_W-1:GRAY_W];
      s2_in.nd[3]  = right_c[PIX_W-1:GRAY_W];
      s2_in.wt[0]  = nb_weight(older_c, cg, hole_ff, thr_ff);
      s2_in.wt[1]  = nb_weight(s1_ff.pix, cg, hole_ff, thr_ff);
      s2_in.wt[2]  = nb_weight(win0_ff, cg, hole_ff, thr_ff);
      s2_in.wt[3]  = nb_weight(right_c, cg, hole_ff, thr_ff);
   end

   // stage 2: products and weight sum
   s3_type s3_in, s3_ff;

   always_comb begin
      s3_in.m = s2_ff.m;
      for (int i = 0; i < NB_COUNT; i++) begin
         s3_in.prod[i] = s2_ff.nd[i] * s2_ff.wt[i];
      end
      s3_in.wsum = WSUM_W'(s2_ff.wt[0]) + WSUM_W'(s2_ff.wt[1])
                 + WSUM_W'(s2_ff.wt[2]) + WSUM_W'(s2_ff.wt[3]);
   end

   // stage 3: weighted sum, then one quotient bit per stage
   dv_type dv_ff [0:QUO_W];
   dv_type dv_in [0:QUO_W];

   always_comb begin
      dv_in[0].m    = s3_ff.m;
      dv_in[0].rem  = SUM_W'(s3_ff.prod[0]) + SUM_W'(s3_ff.prod[1])
                    + SUM_W'(s3_ff.prod[2]) + SUM_W'(s3_ff.prod[3]);
      dv_in[0].q    = '0;
      dv_in[0].wsum = s3_ff.wsum;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int B = QUO_W - 1 - k;
      logic [SUM_W-1:0] dsh;
      always_comb begin
         dsh = SUM_W'(dv_ff[k].wsum) << B;
         dv_in[k+1] = dv_ff[k];
         if (dv_ff[k].rem >= dsh) begin
            dv_in[k+1].rem  = dv_ff[k].rem - dsh;
            dv_in[k+1].q[B] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= '0;
         s2_ff   <= '0;
         s3_ff   <= '0;
         win0_ff <= '0;
         for (int k = 0; k <= QUO_W; k++) begin
            dv_ff[k] <= '0;
         end
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         if (s1_ff.v) begin
            win0_ff <= prev_c;
         end
         for (int k = 0; k <= QUO_W; k++) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   // result queue
   fifo_type             fifo_ff [FIFO_DEPTH];
   fifo_type             push_word, head;
   logic [FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     fifo_cnt_ff;
   logic                 push, pop, drop, phase_ff, first;
   meta_type             tail;

   assign tail = dv_ff[QUO_W].m;
   assign push = tail.v && (tail.out1 || tail.out2);
   assign drop = tail.v && !tail.out1 && !tail.out2;

   always_comb begin
      push_word.d1   = (tail.fill && (dv_ff[QUO_W].wsum != '0)) ? dv_ff[QUO_W].q : tail.cd;
      push_word.d2   = tail.d;
      push_word.row  = tail.row;
      push_word.col  = tail.col;
      push_word.out1 = tail.out1;
      push_word.out2 = tail.out2;
      push_word.fe   = tail.fe;
   end

   assign head          = fifo_ff[rd_ptr_ff];
   assign first         = !phase_ff && head.out1;
   assign rsp_valid     = (fifo_cnt_ff != '0);
   assign rsp_depth_out = first ? head.d1 : head.d2;
   assign rsp_out_row   = first ? (head.row - 1'b1) : head.row;
   assign rsp_out_col   = COL_OUT_W'(head.col);
   assign rsp_run_last  = first ? !head.out2 : 1'b1;
   assign rsp_frame_end = first ? 1'b0 : head.fe;
   assign pop           = rsp_valid && rsp_ready && rsp_run_last;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_comb begin
      cnt_in = cnt_ff + CNT_W'(acc) - CNT_W'(pop) - CNT_W'(drop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         cnt_ff      <= '0;
         phase_ff    <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         fifo_cnt_ff <= fifo_cnt_ff + CNT_W'(push) - CNT_W'(pop);
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
            phase_ff  <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            phase_ff <= 1'b1;
         end
      end
   end

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(FIFO_DEPTH))
      else $error("credit count above queue depth");

   a_queue_in_credit: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= cnt_ff)
      else $error("queue holds more words than items in flight");

   a_second_word: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (fifo_cnt_ff != '0) && head.out2)
      else $error("second result pending without a queued last-row word");

endmodule
